@@ src/sorted_min_priority_queue_defines.svh @@
// Assertion macros shared by the checker of the sorted minimum priority queue.
// Every macro samples on the rising edge of i_clk and is disabled while
// i_rst_n is low, so the module that uses them must have both names in scope.
`ifndef SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_DEFINES_SVH

// General clocked assertion with reset disable.
`define SMPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A signal must hold its value in the cycle after the condition.
`define SMPQ_ASSERT_HOLD(label, cond, sig, msg) \
    `SMPQ_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

@@ src/smpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg
// Types, codes and defaults shared by the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 16;
    localparam int OCC_BITS         = 7;
    localparam int STATUS_BITS      = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_CMP,
        S_POP_RD,
        S_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    ins_start;
        logic    rd_prev;
        logic    rd_head;
        logic    wr_shift;
        logic    wr_new;
        logic    pop_commit;
        logic    set_result;
        t_status result_status;
        logic    load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic is_empty;
        logic is_full;
        logic left_zero;
        logic key_ge;
    } t_stat;

endpackage

@@ src/smpq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_if
// Valid/ready channels for request words and result words of the queue.
// ----------------------------------------------------------------------------
interface smpq_in_if
    import smpq_pkg::*;
#(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, action, key, payload, input ready);
    modport sink   (input valid, action, key, payload, output ready);
endinterface

interface smpq_out_if
    import smpq_pkg::*;
#(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [STATUS_BITS-1:0]  status;
    logic [OCC_BITS-1:0]     occupancy;

    modport source (output valid, out_key, out_payload, status, occupancy, input ready);
    modport sink   (input valid, out_key, out_payload, status, occupancy, output ready);
endinterface

@@ src/smpq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ src/smpq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_dp
// Datapath: circular entry store, head pointer, count, insert scan pointer,
// and the result and output registers.
// ----------------------------------------------------------------------------
module smpq_dp
    import smpq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_action,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic [KEY_BITS-1:0]     o_out_key,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [STATUS_BITS-1:0]  o_status,
    output logic [OCC_BITS-1:0]     o_occupancy
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = KEY_BITS + PAYLOAD_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic                    r_action;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [AW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_count, n_count;
    logic [AW-1:0]           r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]           r_left, n_left;
    logic [KEY_BITS-1:0]     r_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_payload;
    t_status                 r_res_status;
    logic [KEY_BITS-1:0]     r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    t_status                 r_out_status;
    logic [OCC_BITS-1:0]     r_out_occ;

    logic [AW-1:0]           prev_ptr;
    logic [AW-1:0]           next_head;
    logic [SW-1:0]           tail_sum;
    logic [AW-1:0]           tail_ptr;
    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [EW-1:0]           ram_wr_data;
    logic                    ram_rd_en;
    logic [AW-1:0]           ram_rd_addr;
    logic [EW-1:0]           ram_rd_data;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    assign prev_ptr  = (r_wr_ptr == '0) ? LAST_ADDR : r_wr_ptr - 1'b1;
    assign next_head = (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
    // The tail sits count places after the head; the sum stays below twice DEPTH.
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_ptr  = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);

    assign rd_key     = ram_rd_data[EW-1:PAYLOAD_BITS];
    assign rd_payload = ram_rd_data[PAYLOAD_BITS-1:0];

    assign ram_rd_en   = i_cmd.rd_prev | i_cmd.rd_head;
    assign ram_rd_addr = i_cmd.rd_head ? r_head : prev_ptr;
    assign ram_wr_en   = i_cmd.wr_shift | i_cmd.wr_new;
    assign ram_wr_addr = r_wr_ptr;
    assign ram_wr_data = i_cmd.wr_new ? {r_key, r_payload} : ram_rd_data;

    smpq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_wr_ptr = r_wr_ptr;
        n_left   = r_left;
        if (i_cmd.ins_start) begin
            n_wr_ptr = tail_ptr;
            n_left   = r_count;
        end
        if (i_cmd.wr_shift) begin
            n_wr_ptr = prev_ptr;
            n_left   = r_left - 1'b1;
        end
        if (i_cmd.wr_new) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.pop_commit) begin
            n_head  = next_head;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_ptr <= n_wr_ptr;
        r_left   <= n_left;
        if (i_cmd.load_item) begin
            r_action  <= i_action;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
        if (i_cmd.set_result) begin
            r_res_key     <= i_cmd.pop_commit ? rd_key : '0;
            r_res_payload <= i_cmd.pop_commit ? rd_payload : '0;
            r_res_status  <= i_cmd.result_status;
        end
        if (i_cmd.load_out) begin
            r_out_key     <= r_res_key;
            r_out_payload <= r_res_payload;
            r_out_status  <= r_res_status;
            r_out_occ     <= OCC_BITS'(r_count);
        end
    end

    assign o_stat.is_pop    = (r_action == ACT_POP);
    assign o_stat.is_empty  = (r_count == '0);
    assign o_stat.is_full   = (r_count == CW'(DEPTH));
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.key_ge    = (rd_key >= r_key);

    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_status      = r_out_status;
    assign o_occupancy   = r_out_occ;
endmodule

@@ src/smpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_ctrl
// Controller: sequences the pop read and the tail-to-head insert scan, and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module smpq_ctrl
    import smpq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.result_status = ST_OK;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_pop) begin
                    if (i_stat.is_empty) begin
                        o_cmd.set_result    = 1'b1;
                        o_cmd.result_status = ST_EMPTY;
                        n_state             = S_FIN;
                    end else begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_POP_RD;
                    end
                end else begin
                    if (i_stat.is_full) begin
                        o_cmd.set_result    = 1'b1;
                        o_cmd.result_status = ST_FULL;
                        n_state             = S_FIN;
                    end else begin
                        o_cmd.ins_start = 1'b1;
                        n_state         = S_INS_RD;
                    end
                end
            end
            S_POP_RD: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.set_result = 1'b1;
                n_state          = S_FIN;
            end
            S_INS_RD: begin
                // With no entries left to inspect, the new word goes at the head.
                if (i_stat.left_zero) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.set_result = 1'b1;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.key_ge) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = S_INS_RD;
                end else begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.set_result = 1'b1;
                    n_state          = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

@@ src/sorted_min_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Pop: the head entry becomes the result word; empty or full: a zeroed word.
// Insert shifting s entries scans from the tail; each shifted entry
// costs one RAM read and one RAM write through the single entry memory.
// A new request word is taken after the result reaches the output registers.
// Synchronous reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue
    import smpq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpq_in_if.sink    i_in,
    smpq_out_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smpq_dp #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_in.action),
        .i_key         (i_in.key),
        .i_payload     (i_in.payload),
        .o_out_key     (o_out.out_key),
        .o_out_payload (o_out.out_payload),
        .o_status      (o_out.status),
        .o_occupancy   (o_out.occupancy)
    );
endmodule

@@ src/smpq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_chk
// Port-level checks of the sorted minimum priority queue, bound to the top.
// ----------------------------------------------------------------------------
`include "sorted_min_priority_queue_defines.svh"

module smpq_chk
    import smpq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [KEY_BITS-1:0]     i_out_key,
    input logic [PAYLOAD_BITS-1:0] i_out_payload,
    input logic [STATUS_BITS-1:0]  i_out_status,
    input logic [OCC_BITS-1:0]     i_out_occupancy
);
    localparam bit OCC_WRAPS = (DEPTH > (2 ** OCC_BITS - 1));
    localparam logic [OCC_BITS-1:0] OCC_DEPTH = OCC_BITS'(DEPTH);

    logic out_stall;
    assign out_stall = i_out_valid && !i_out_ready;

    // One word is in work at a time, so ready drops right after an accept.
    `SMPQ_ASSERT(a_one_in_flight, (i_in_valid && i_in_ready) |=> !i_in_ready, "request accepted while busy")

    `SMPQ_ASSERT(a_occ_bound, OCC_WRAPS || !i_out_valid || (i_out_occupancy <= OCC_DEPTH), "occupancy above depth")

    `SMPQ_ASSERT(a_empty_word, (i_out_valid && i_out_status == ST_EMPTY) |-> (i_out_key == '0 && i_out_payload == '0 && i_out_occupancy == '0), "empty pop result not cleared")

    `SMPQ_ASSERT(a_full_word, (i_out_valid && i_out_status == ST_FULL) |-> (i_out_occupancy == OCC_DEPTH && i_out_key == '0), "full insert result inconsistent")

    `SMPQ_ASSERT_HOLD(a_out_hold, out_stall, i_out_key, "stalled result key changed")
endmodule

bind sorted_min_priority_queue smpq_chk #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_smpq_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_key       (o_out.out_key),
    .i_out_payload   (o_out.out_payload),
    .i_out_status    (o_out.status),
    .i_out_occupancy (o_out.occupancy)
);
